### sv/crd_pkg.sv
// Package for the camera ray direction block: widths, types, defaults and the
// Q1.15 output sign and saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crd_pkg;

    // Image size defaults
    localparam int DEF_IMAGE_WIDTH  = 1024;
    localparam int DEF_IMAGE_HEIGHT = 768;

    // Field widths
    localparam int PIX_W   = 10;
    localparam int FOCAL_W = 16;
    localparam int DIR_W   = 16;

    // Internal widths
    localparam int VEC_W = 17;               // signed doubled-unit component
    localparam int SQ_W  = 32;               // square of one component
    localparam int S_W   = 33;               // sum of three squares
    localparam int R_W   = 68;               // signed remainder of the rounding search
    localparam int P_W   = 51;               // signed (2n-1)*s term
    localparam int Q_W   = 16;               // magnitude, 0 to 32768 for a non-zero vector
    localparam int NCOMP = 3;

    localparam logic [FOCAL_W-1:0] FOCAL_RESET = FOCAL_W'(1024);
    localparam logic [Q_W-1:0]     Q15_ONE     = Q_W'(32768);
    localparam logic [DIR_W-1:0]   Q15_MAX     = DIR_W'(32767);

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic        [SQ_W-1:0]  t_sq;
    typedef logic        [S_W-1:0]   t_sum;
    typedef logic signed [R_W-1:0]   t_rem;
    typedef logic signed [P_W-1:0]   t_prd;
    typedef logic        [Q_W-1:0]   t_mag;
    typedef logic        [DIR_W-1:0] t_dir;

    // Apply sign and saturate a rounded magnitude to Q1.15; a zero-length vector gives zero
    function automatic t_dir q15_out(input logic zero, input logic neg, input t_mag mag);
        t_dir res;
        if (zero) begin
            res = '0;
        end else if (neg) begin
            res = DIR_W'(-mag);
        end else if (mag > t_mag'(Q15_MAX)) begin
            res = Q15_MAX;
        end else begin
            res = DIR_W'(mag);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/camera_ray_direction.sv
// Top level of the camera ray direction block: a pipelined unit-vector
// normaliser for pinhole primary rays. Depends on crd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel: i_valid, i_pixel_x, i_pixel_y, with o_stall back to the
//   sender. An item is taken at a rising edge with i_valid high, o_stall low.
//   Output channel: o_valid, o_dir_x, o_dir_y, o_dir_z, with i_stall from the
//   receiver. An item leaves at an edge with o_valid high, i_stall low.
//   Configuration: i_cfg_valid with i_focal_twice, o_cfg_ready is always high;
//   write it only while no item is in flight.
// Throughput and stages
//   One item per cycle sustained while i_stall stays low. The pipe holds
//   three setup stages (offsets, squares, sum), sixteen stages of the rounding
//   search (one magnitude bit per stage for all three components) and the
//   output stage.
// Stall behaviour
//   Each stage holds its item while the stage after it is full and blocked;
//   empty stages keep filling, so items are still accepted while a result
//   waits. o_stall rises only when every stage holds an item.
// Reset
//   Synchronous, active low: empties the pipe and sets focal_twice to 1024.
module camera_ray_direction
    import crd_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [FOCAL_W-1:0] i_focal_twice,
    // pixel items in
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [PIX_W-1:0]   i_pixel_x,
    input  wire logic [PIX_W-1:0]   i_pixel_y,
    // direction items out
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [DIR_W-1:0] o_dir_x,
    output logic signed [DIR_W-1:0] o_dir_y,
    output logic signed [DIR_W-1:0] o_dir_z
);

    // Stage map
    localparam int NSTEP  = Q_W;
    localparam int ST_IN  = 0;
    localparam int ST_SQ  = 1;
    localparam int ST_SUM = 2;
    localparam int ST_OUT = ST_SUM + NSTEP + 1;
    localparam int NS     = ST_OUT + 1;
    localparam int PAD_W  = VEC_W - PIX_W - 1;

    localparam t_vec OFS_X = VEC_W'(IMAGE_WIDTH);
    localparam t_vec OFS_Y = VEC_W'(IMAGE_HEIGHT);

    // Configuration register
    logic [FOCAL_W-1:0] r_focal;

    // Stage valids and advance chain
    logic [NS-1:0] r_vld;
    logic [NS:0]   adv;

    // Payload
    t_vec r_vec [NCOMP];
    t_sq  r_sq  [NCOMP];
    logic r_neg [ST_OUT-1:ST_SQ][NCOMP];
    t_sum r_sum [NSTEP+1];
    logic r_zero [NSTEP+1];
    t_rem r_rem [NSTEP+1][NCOMP];
    t_prd r_prd [NSTEP+1][NCOMP];
    t_mag r_qt  [NSTEP+1][NCOMP];
    t_dir r_dir [NCOMP];

    // Next values
    logic signed [2*VEC_W-1:0] n_prod [NCOMP];
    t_sum n_sum;
    t_rem n_rem [NSTEP][NCOMP];
    t_prd n_prd [NSTEP][NCOMP];
    t_mag n_qt  [NSTEP][NCOMP];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= FOCAL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_focal <= i_focal_twice;
        end
    end

    // A stage may load when it is empty or its contents move on
    assign adv[NS] = !i_stall;
    for (genvar g = 0; g < NS; g++) begin : g_adv
        assign adv[g] = !r_vld[g] || adv[g+1];
    end
    assign o_stall = !adv[ST_IN];
    assign o_valid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[ST_IN]) begin
                r_vld[ST_IN] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Squares and their sum, then the start of the rounding search:
    // remainder = m^2 * 2^32 - s for a trial magnitude of zero, term = -s.
    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            n_prod[i] = r_vec[i] * r_vec[i];
        end
        n_sum = S_W'(r_sq[0]) + S_W'(r_sq[1]) + S_W'(r_sq[2]);
    end

    // One magnitude bit per stage: trial n + 2^k keeps the bit when
    // (2n - 1 + 2^(k+1))^2 * s still fits under m^2 * 2^32.
    always_comb begin
        t_rem prd_ext;
        t_rem sum_ext;
        t_rem trial;
        for (int j = 0; j < NSTEP; j++) begin
            for (int i = 0; i < NCOMP; i++) begin
                prd_ext = R_W'(r_prd[j][i]);
                sum_ext = $signed({{(R_W-S_W){1'b0}}, r_sum[j]});
                trial   = r_rem[j][i] - (prd_ext <<< (NSTEP + 1 - j))
                          - (sum_ext <<< (2 * (NSTEP - j)));
                if (!trial[R_W-1]) begin
                    n_rem[j][i] = trial;
                    n_prd[j][i] = r_prd[j][i]
                                  + ($signed({{(P_W-S_W){1'b0}}, r_sum[j]}) <<< (NSTEP - j));
                    n_qt[j][i]  = r_qt[j][i] | (t_mag'(1) << (NSTEP - 1 - j));
                end else begin
                    n_rem[j][i] = r_rem[j][i];
                    n_prd[j][i] = r_prd[j][i];
                    n_qt[j][i]  = r_qt[j][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // doubled-unit vector
        if (adv[ST_IN]) begin
            r_vec[0] <= $signed({{PAD_W{1'b0}}, i_pixel_x, 1'b1}) - OFS_X;
            r_vec[1] <= $signed({{PAD_W{1'b0}}, i_pixel_y, 1'b1}) - OFS_Y;
            r_vec[2] <= $signed({1'b0, r_focal});
        end
        // squares
        if (adv[ST_SQ]) begin
            for (int i = 0; i < NCOMP; i++) begin
                r_sq[i]         <= n_prod[i][SQ_W-1:0];
                r_neg[ST_SQ][i] <= r_vec[i][VEC_W-1];
            end
        end
        // sum and search start
        if (adv[ST_SUM]) begin
            r_sum[0]  <= n_sum;
            r_zero[0] <= (n_sum == '0);
            for (int i = 0; i < NCOMP; i++) begin
                r_neg[ST_SUM][i] <= r_neg[ST_SQ][i];
                r_rem[0][i] <= $signed({{(R_W-SQ_W-32){1'b0}}, r_sq[i], 32'd0})
                               - $signed({{(R_W-S_W){1'b0}}, n_sum});
                r_prd[0][i] <= -$signed({{(P_W-S_W){1'b0}}, n_sum});
                r_qt[0][i]  <= '0;
            end
        end
        // search steps
        for (int j = 0; j < NSTEP; j++) begin
            if (adv[ST_SUM + 1 + j]) begin
                r_sum[j+1]  <= r_sum[j];
                r_zero[j+1] <= r_zero[j];
                for (int i = 0; i < NCOMP; i++) begin
                    r_neg[ST_SUM + 1 + j][i] <= r_neg[ST_SUM + j][i];
                    r_rem[j+1][i] <= n_rem[j][i];
                    r_prd[j+1][i] <= n_prd[j][i];
                    r_qt[j+1][i]  <= n_qt[j][i];
                end
            end
        end
        // sign, saturate, hold for the receiver
        if (adv[ST_OUT]) begin
            for (int i = 0; i < NCOMP; i++) begin
                r_dir[i] <= q15_out(r_zero[NSTEP], r_neg[ST_OUT-1][i], r_qt[NSTEP][i]);
            end
        end
    end

    assign o_dir_x = $signed(r_dir[0]);
    assign o_dir_y = $signed(r_dir[1]);
    assign o_dir_z = $signed(r_dir[2]);

    // The input is held back only when the whole pipe is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // An accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[ST_IN])
        else $error("accepted item lost at the first stage");

    // The search never passes an exact unit magnitude; a zero-length vector
    // runs the search to all ones and is dropped at the output stage
    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_OUT-1] && !r_zero[NSTEP])
        |-> ((r_qt[NSTEP][0] <= Q15_ONE) && (r_qt[NSTEP][1] <= Q15_ONE)
             && (r_qt[NSTEP][2] <= Q15_ONE)))
        else $error("rounded magnitude above one");

    // The viewing axis component is never negative
    a_dir_z_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_dir_z[DIR_W-1])
        else $error("negative z direction");

endmodule

`default_nettype wire

### verif/crd_ray_checker.sv
`timescale 1ns / 1ps
// Checker for camera_ray_direction: it watches the pixel, direction and focal channels,
// predicts each direction item and compares it field by field. Depends on crd_pkg.
module crd_ray_checker
    import crd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [FOCAL_W-1:0] i_focal_twice,
    input  wire logic               i_pix_valid,
    input  wire logic               i_pix_stall,
    input  wire logic [PIX_W-1:0]   i_pixel_x,
    input  wire logic [PIX_W-1:0]   i_pixel_y,
    input  wire logic               i_dir_valid,
    input  wire logic               i_dir_stall,
    input  wire logic [DIR_W-1:0]   i_dir_x,
    input  wire logic [DIR_W-1:0]   i_dir_y,
    input  wire logic [DIR_W-1:0]   i_dir_z,
    output int                      o_errors,
    output int                      o_outstanding,
    output int                      o_checked
);

    typedef struct packed {
        t_dir x;
        t_dir y;
        t_dir z;
    } t_ray_dir;

    logic [FOCAL_W-1:0] focal_shadow = FOCAL_RESET;
    t_ray_dir           dir_queue[$];
    int                 fail_count = 0;
    int                 check_count = 0;

    // Largest n in 0..32768 with (2n-1)^2 <= (|v| * 2^16)^2 / sumsq, then sign and saturate.
    function automatic t_dir unit_q15(input longint v, input longint unsigned sumsq);
        logic [127:0]    scaled;
        logic [127:0]    limit;
        logic [127:0]    odd_sq;
        longint unsigned mag;
        int              lo;
        int              hi;
        int              mid;
        t_dir            res;
        mag    = (v < 0) ? -v : v;
        scaled = {64'd0, mag} << 16;
        scaled = scaled * scaled;
        limit  = scaled / {64'd0, sumsq};
        lo     = 0;
        hi     = 32768;
        while (lo < hi) begin
            mid    = (lo + hi + 1) / 2;
            odd_sq = 128'(2 * mid - 1) * 128'(2 * mid - 1);
            if (odd_sq <= limit) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        if (v < 0) begin
            res = t_dir'(-lo);
        end else if (lo > 32767) begin
            res = Q15_MAX;
        end else begin
            res = t_dir'(lo);
        end
        return res;
    endfunction

    // Doubled-unit ray through the pixel centre, normalised to Q1.15
    function automatic t_ray_dir trace_dir(input logic [PIX_W-1:0] px,
                                           input logic [PIX_W-1:0] py,
                                           input logic [FOCAL_W-1:0] focal);
        longint          a;
        longint          b;
        longint          c;
        longint unsigned sumsq;
        t_ray_dir        d;
        a     = 2 * longint'(px) + 1 - longint'(DEF_IMAGE_WIDTH);
        b     = 2 * longint'(py) + 1 - longint'(DEF_IMAGE_HEIGHT);
        c     = longint'(focal);
        sumsq = a * a + b * b + c * c;
        if (sumsq == 0) begin
            d = '0;
        end else begin
            d.x = unit_q15(a, sumsq);
            d.y = unit_q15(b, sumsq);
            d.z = unit_q15(c, sumsq);
        end
        return d;
    endfunction

    task automatic check_field(input string name, input t_dir want, input t_dir got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_ray_dir want;
        if (!i_rst_n) begin
            focal_shadow <= FOCAL_RESET;
            dir_queue.delete();
        end else begin
            if (i_dir_valid && !i_dir_stall) begin
                if (dir_queue.size() == 0) begin
                    $error("direction item (%0d, %0d, %0d) with none expected",
                           $signed(i_dir_x), $signed(i_dir_y), $signed(i_dir_z));
                    fail_count++;
                end else begin
                    want = dir_queue.pop_front();
                    check_field("dir_x", want.x, i_dir_x);
                    check_field("dir_y", want.y, i_dir_y);
                    check_field("dir_z", want.z, i_dir_z);
                    check_count++;
                end
            end
            // Predict with the focal value in force before this edge
            if (i_pix_valid && !i_pix_stall) begin
                dir_queue.push_back(trace_dir(i_pixel_x, i_pixel_y, focal_shadow));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                focal_shadow <= i_focal_twice;
            end
        end
        o_outstanding <= dir_queue.size();
        o_errors      <= fail_count;
        o_checked     <= check_count;
    end

endmodule

### verif/camera_ray_direction_tb.sv
`timescale 1ns / 1ps
// Testbench top for camera_ray_direction: clock, reset, pixel and focal stimulus,
// receiver stalls and the verdict. Depends on crd_pkg and crd_ray_checker.
module camera_ray_direction_tb;
    import crd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest correct run
    localparam int DRAIN_CYCLES = 40;      // idle time for stray items after the drain
    localparam int HOLD_CYCLES  = 100;     // long enough to fill all twenty stages
    localparam int PHASE_ITEMS  = 190;
    localparam int NUM_PHASES   = 8;
    localparam int CALM_PHASE   = 3;
    localparam int SQUEEZE_PHASE = 6;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic [FOCAL_W-1:0] i_focal_twice = FOCAL_RESET;
    logic               i_valid       = 1'b0;
    logic [PIX_W-1:0]   i_pixel_x     = '0;
    logic [PIX_W-1:0]   i_pixel_y     = '0;
    logic               i_stall       = 1'b0;
    logic               o_cfg_ready;
    logic               o_stall;
    logic               o_valid;
    logic signed [DIR_W-1:0] o_dir_x;
    logic signed [DIR_W-1:0] o_dir_y;
    logic signed [DIR_W-1:0] o_dir_z;

    int errors;
    int outstanding;
    int checked;
    int cycles          = 0;
    int pixels_sent     = 0;
    int blocked_cycles  = 0;
    int focal_settings  = 0;
    bit calm            = 1'b0;  // no idling on either side while set
    bit squeeze_req     = 1'b0;  // ask the receiver for one long hold-off

    camera_ray_direction DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_focal_twice (i_focal_twice),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_dir_x       (o_dir_x),
        .o_dir_y       (o_dir_y),
        .o_dir_z       (o_dir_z)
    );

    crd_ray_checker ray_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_focal_twice (i_focal_twice),
        .i_pix_valid   (i_valid),
        .i_pix_stall   (o_stall),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_dir_valid   (o_valid),
        .i_dir_stall   (i_stall),
        .i_dir_x       (o_dir_x),
        .i_dir_y       (o_dir_y),
        .i_dir_z       (o_dir_z),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Count cycles, and cycles on which the block pushed back on an offered item
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_valid && o_stall) begin
            blocked_cycles <= blocked_cycles + 1;
        end
    end

    // Watchdog: abandon a run that has hung
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
        $display("camera_ray_direction: mismatch");
        $finish;
    end

    // Receiver: stall about one cycle in five, never in the calm phase, and once
    // hold off long enough for the pipe to fill and push back on the sender.
    initial begin
        forever begin
            @(posedge i_clk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (calm) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 21);
            end
        end
    end

    // Offer one pixel item, with random idle cycles ahead of it; hold it until taken.
    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
        while (!calm && $urandom_range(0, 99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pixels_sent++;
    endtask

    // Write the focal register once the pipe has drained
    task automatic write_focal(input logic [FOCAL_W-1:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_focal_twice <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        focal_settings++;
    endtask

    initial begin
        int                 phase;
        int                 pick;
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [FOCAL_W-1:0] focal;

        // Hold reset low from the start, then release it for good
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset focal value: corners, the four pixels
        // around the image centre, rows below the image and alternating bits.
        send_pixel(10'd0,    10'd0);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0,    10'd767);
        send_pixel(10'd1023, 10'd767);
        send_pixel(10'd511,  10'd383);
        send_pixel(10'd512,  10'd384);
        send_pixel(10'd511,  10'd384);
        send_pixel(10'd512,  10'd383);
        send_pixel(10'd0,    10'd1023);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512,  10'd1023);
        send_pixel(10'd1023, 10'd768);
        send_pixel(10'd682,  10'd341);
        send_pixel(10'd341,  10'd682);

        // Zero focal: the ray lies in the image plane; the far edges at the centre
        // row drive dir_x to full scale, saturating on the positive side.
        write_focal('0);
        send_pixel(10'd511,  10'd383);
        send_pixel(10'd512,  10'd384);
        send_pixel(10'd1023, 10'd383);
        send_pixel(10'd0,    10'd384);
        send_pixel(10'd512,  10'd0);

        // Largest focal: dir_z close to +1.0
        write_focal('1);
        send_pixel(10'd511,  10'd383);
        send_pixel(10'd0,    10'd0);
        send_pixel(10'd1023, 10'd1023);

        // Smallest non-zero focal
        write_focal(FOCAL_W'(1));
        send_pixel(10'd512,  10'd384);

        // Random phases, each under its own focal setting
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       focal = FOCAL_W'($urandom_range(1, 65535));
                1:       focal = FOCAL_W'(1);
                2:       focal = FOCAL_W'($urandom_range(256, 2048));
                3:       focal = '1;
                4:       focal = '0;
                5:       focal = FOCAL_W'($urandom_range(1, 255));
                6:       focal = FOCAL_W'($urandom_range(1, 65535));
                default: focal = FOCAL_RESET;
            endcase
            write_focal(focal);
            calm = (phase == CALM_PHASE);
            if (phase == SQUEEZE_PHASE) begin
                squeeze_req = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    // near the centre, where components pass through zero
                    x = PIX_W'($urandom_range(500, 523));
                    y = PIX_W'($urandom_range(372, 395));
                end else begin
                    x = PIX_W'($urandom_range(0, 1023));
                    y = (pick < 20) ? PIX_W'($urandom_range(768, 1023))
                                    : PIX_W'($urandom_range(0, 767));
                end
                send_pixel(x, y);
            end
        end
        calm = 1'b0;

        // Drop valid, wait for every expected item, then allow stray ones to show
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d pixel items under %0d focal writes; %0d directions checked",
                 pixels_sent, focal_settings, checked);
        $display("input held back on %0d cycles; %0d cycles in all", blocked_cycles, cycles);
        if (errors == 0) begin
            $display("camera_ray_direction: match");
        end else begin
            $display("camera_ray_direction: mismatch");
        end
        $finish;
    end

endmodule

### camera_ray_direction.f
sv/crd_pkg.sv
sv/camera_ray_direction.sv
verif/crd_ray_checker.sv
verif/camera_ray_direction_tb.sv
